// ===== hw/rtl/sfce_pkg.sv =====
// Shared types and constants for the sync frame channel extractor.
`timescale 1ns / 1ps
`default_nettype none

package sfce_pkg;

    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int SCAN_W   = 9;
    localparam int SLOT_W   = 6;
    localparam int PKT_W    = 17;
    localparam int DEST_W   = 15;
    localparam int INDEX_W  = 8;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [WORD_W-1:0] SYNC_WORD    = 16'hCCDD;
    localparam logic [BYTE_W-1:0] TEST_CHANNEL = 8'd3;
    localparam logic [BYTE_W-1:0] FIRST_SLOT   = 8'd0;
    localparam logic [SLOT_W-1:0] SLOT_SAT     = 6'd63;

    localparam logic              WORK_MODE_RST      = 1'b1;
    localparam logic [BYTE_W-1:0] SELECT_CHANNEL_RST = 8'd0;
    localparam logic [BYTE_W-1:0] SELECT_SLOT_RST    = 8'd0;
    localparam logic [SCAN_W-1:0] MAX_SCANS_RST      = 9'd0;
    localparam logic [PKT_W-1:0]  PACKET_WORDS_RST   = 17'd112680;

    localparam logic MODE_ASSEMBLE = 1'b0;
    localparam logic MODE_NORMAL   = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WORK_MODE      = 3'd0,
        REG_SELECT_CHANNEL = 3'd1,
        REG_SELECT_SLOT    = 3'd2,
        REG_MAX_SCANS      = 3'd3,
        REG_PACKET_WORDS   = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sync_frame_channel_extractor_core.sv =====
// Sync frame channel extractor: frame search, header decode and payload output.
// Path: an accepted item is held in the input register, and its result is
// registered in the result register, from which its handshake completes.
// Throughput: one item per cycle while out_ready is high; the single pass
// from input register to result register sets that figure.
// Reset: rst_n clears all packet state and loads the register reset values;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_channel_extractor_core #(
    parameter int FRAME_WORDS    = 626,
    parameter int SCAN_STRIDE    = 624,
    parameter int MAX_SLOTS      = 32,
    parameter int MAX_SCAN_COUNT = 256
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sfce_pkg::APB_AW-1:0]          paddr,
    input  wire logic [sfce_pkg::APB_DW-1:0]          pwdata,
    output logic      [sfce_pkg::APB_DW-1:0]          prdata,
    output logic                                      pready,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [sfce_pkg::WORD_W-1:0]   sample_word,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [sfce_pkg::WORD_W-1:0]        payload_word,
    output logic        [sfce_pkg::INDEX_W-1:0]       scan_index,
    output logic        [sfce_pkg::DEST_W-1:0]        dest_offset,
    output logic                                      frame_end
);

    localparam int FP_W    = $clog2(FRAME_WORDS);
    localparam int SW_W    = $clog2(SCAN_STRIDE + 1);
    localparam int OFF_RAW = sfce_pkg::SLOT_W + SW_W + FP_W;
    localparam int OFF_W   = (OFF_RAW > sfce_pkg::DEST_W) ? OFF_RAW : sfce_pkg::DEST_W;
    localparam int PW_EXT  = sfce_pkg::PKT_W + 1;

    localparam logic [FP_W:0]   FP_LAST_PAYLOAD = (FP_W+1)'(FRAME_WORDS - 2);
    localparam logic [FP_W:0]   FP_FRAME_END    = (FP_W+1)'(FRAME_WORDS);
    localparam logic [FP_W:0]   FP_HEADER       = (FP_W+1)'(1);
    localparam logic [FP_W:0]   FP_FIRST_PAY    = (FP_W+1)'(2);
    localparam logic [PW_EXT-1:0] FIT_SPAN      = PW_EXT'(FRAME_WORDS - 2);
    localparam logic [sfce_pkg::SCAN_W-1:0] SCAN_CAP = sfce_pkg::SCAN_W'(MAX_SCAN_COUNT);
    localparam logic [sfce_pkg::SLOT_W:0]   SLOT_CAP = (sfce_pkg::SLOT_W+1)'(MAX_SLOTS);
    localparam logic [SW_W-1:0] STRIDE          = SW_W'(SCAN_STRIDE);

    // configuration registers
    logic                             work_mode_reg;
    logic [sfce_pkg::BYTE_W-1:0]      select_channel_reg;
    logic [sfce_pkg::BYTE_W-1:0]      select_slot_reg;
    logic [sfce_pkg::SCAN_W-1:0]      max_scans_reg;
    logic [sfce_pkg::PKT_W-1:0]       packet_words_reg;

    // packet state
    logic [sfce_pkg::PKT_W-1:0]       packet_position_reg, packet_position_next;
    logic [FP_W-1:0]                  frame_position_reg, frame_position_next;
    logic                             in_frame_reg, in_frame_next;
    logic                             frame_selected_reg, frame_selected_next;
    logic [sfce_pkg::SCAN_W-1:0]      scans_done_reg, scans_done_next;
    logic [sfce_pkg::SLOT_W-1:0]      slot_in_scan_reg, slot_in_scan_next;
    logic                             scan_open_reg, scan_open_next;
    logic                             packet_finished_reg, packet_finished_next;

    // input and result registers
    logic                             in_valid_reg;
    logic [sfce_pkg::WORD_W-1:0]      in_word_reg;
    logic                             out_valid_reg;
    logic [sfce_pkg::WORD_W-1:0]      payload_word_reg;
    logic [sfce_pkg::INDEX_W-1:0]     scan_index_reg;
    logic [sfce_pkg::DEST_W-1:0]      dest_offset_reg;
    logic                             frame_end_reg;

    logic                             cfg_write;
    sfce_pkg::cfg_reg_t               cfg_sel;
    logic                             advance;
    logic                             emit;
    logic [sfce_pkg::INDEX_W-1:0]     emit_index;
    logic [sfce_pkg::DEST_W-1:0]      emit_offset;
    logic                             emit_last;

    logic [FP_W:0]                    fp_ext;
    logic [FP_W:0]                    fp_inc;
    logic [FP_W-1:0]                  pay_idx;
    logic [OFF_W-1:0]                 test_offset;
    logic [sfce_pkg::SCAN_W-1:0]      scan_limit;
    logic [sfce_pkg::SCAN_W-1:0]      scans_inc;
    logic [sfce_pkg::SCAN_W-1:0]      scans_dec;
    logic [sfce_pkg::BYTE_W-1:0]      hdr_channel;
    logic [sfce_pkg::BYTE_W-1:0]      hdr_slot;
    logic                             sync_fits;
    logic                             packet_wrap;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = sfce_pkg::cfg_reg_t'(paddr[sfce_pkg::APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_mode_reg      <= sfce_pkg::WORK_MODE_RST;
            select_channel_reg <= sfce_pkg::SELECT_CHANNEL_RST;
            select_slot_reg    <= sfce_pkg::SELECT_SLOT_RST;
            max_scans_reg      <= sfce_pkg::MAX_SCANS_RST;
            packet_words_reg   <= sfce_pkg::PACKET_WORDS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                sfce_pkg::REG_WORK_MODE:      work_mode_reg      <= pwdata[0];
                sfce_pkg::REG_SELECT_CHANNEL: select_channel_reg <= pwdata[sfce_pkg::BYTE_W-1:0];
                sfce_pkg::REG_SELECT_SLOT:    select_slot_reg    <= pwdata[sfce_pkg::BYTE_W-1:0];
                sfce_pkg::REG_MAX_SCANS:      max_scans_reg      <= pwdata[sfce_pkg::SCAN_W-1:0];
                sfce_pkg::REG_PACKET_WORDS:   packet_words_reg   <= pwdata[sfce_pkg::PKT_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            sfce_pkg::REG_WORK_MODE:      prdata = sfce_pkg::APB_DW'(work_mode_reg);
            sfce_pkg::REG_SELECT_CHANNEL: prdata = sfce_pkg::APB_DW'(select_channel_reg);
            sfce_pkg::REG_SELECT_SLOT:    prdata = sfce_pkg::APB_DW'(select_slot_reg);
            sfce_pkg::REG_MAX_SCANS:      prdata = sfce_pkg::APB_DW'(max_scans_reg);
            sfce_pkg::REG_PACKET_WORDS:   prdata = sfce_pkg::APB_DW'(packet_words_reg);
            default:                      prdata = '0;
        endcase
    end

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // datapath helpers
    assign fp_ext      = {1'b0, frame_position_reg};
    assign fp_inc      = fp_ext + (FP_W+1)'(1);
    assign pay_idx     = frame_position_reg - FP_W'(2);
    assign test_offset = OFF_W'(slot_in_scan_reg) * OFF_W'(STRIDE) + OFF_W'(pay_idx);
    assign scans_inc   = scans_done_reg + sfce_pkg::SCAN_W'(1);
    assign scans_dec   = scans_done_reg - sfce_pkg::SCAN_W'(1);
    assign hdr_channel = in_word_reg[sfce_pkg::WORD_W-1:sfce_pkg::BYTE_W];
    assign hdr_slot    = in_word_reg[sfce_pkg::BYTE_W-1:0];
    assign sync_fits   = ({1'b0, packet_position_reg} + FIT_SPAN) < {1'b0, packet_words_reg};
    assign packet_wrap = ({1'b0, packet_position_reg} + PW_EXT'(1)) >= {1'b0, packet_words_reg};

    always_comb
    begin
        if (max_scans_reg == '0 || max_scans_reg > SCAN_CAP)
        begin
            scan_limit = SCAN_CAP;
        end
        else
        begin
            scan_limit = max_scans_reg;
        end
    end

    always_comb
    begin
        packet_position_next = packet_position_reg;
        frame_position_next  = frame_position_reg;
        in_frame_next        = in_frame_reg;
        frame_selected_next  = frame_selected_reg;
        scans_done_next      = scans_done_reg;
        slot_in_scan_next    = slot_in_scan_reg;
        scan_open_next       = scan_open_reg;
        packet_finished_next = packet_finished_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        emit_index  = scans_dec[sfce_pkg::INDEX_W-1:0];
        emit_offset = (work_mode_reg == sfce_pkg::MODE_ASSEMBLE)
                    ? test_offset[sfce_pkg::DEST_W-1:0]
                    : sfce_pkg::DEST_W'(pay_idx);

        if (in_frame_reg)
        begin
            if (fp_ext == FP_HEADER)
            begin
                frame_selected_next = 1'b0;
                if (work_mode_reg == sfce_pkg::MODE_NORMAL)
                begin
                    if (hdr_channel == select_channel_reg && hdr_slot == select_slot_reg)
                    begin
                        frame_selected_next = 1'b1;
                        scans_done_next     = scans_inc;
                        if (scans_inc >= scan_limit)
                        begin
                            packet_finished_next = 1'b1;
                        end
                    end
                end
                else if (hdr_channel == sfce_pkg::TEST_CHANNEL)
                begin
                    if (hdr_slot == sfce_pkg::FIRST_SLOT)
                    begin
                        if (scans_done_reg >= scan_limit)
                        begin
                            packet_finished_next = 1'b1;
                            in_frame_next        = 1'b0;
                        end
                        else
                        begin
                            scans_done_next   = scans_inc;
                            scan_open_next    = 1'b1;
                            slot_in_scan_next = '0;
                        end
                    end
                    if (in_frame_next && scan_open_next &&
                        {1'b0, slot_in_scan_next} < SLOT_CAP)
                    begin
                        frame_selected_next = 1'b1;
                    end
                end
            end
            else if (fp_ext >= FP_FIRST_PAY && fp_ext <= FP_LAST_PAYLOAD && frame_selected_reg)
            begin
                emit      = 1'b1;
                emit_last = (fp_ext == FP_LAST_PAYLOAD);
                if (emit_last && work_mode_reg == sfce_pkg::MODE_ASSEMBLE &&
                    slot_in_scan_reg < sfce_pkg::SLOT_SAT)
                begin
                    slot_in_scan_next = slot_in_scan_reg + sfce_pkg::SLOT_W'(1);
                end
            end

            if (in_frame_next)
            begin
                if (fp_inc >= FP_FRAME_END)
                begin
                    in_frame_next       = 1'b0;
                    frame_selected_next = 1'b0;
                    frame_position_next = '0;
                end
                else
                begin
                    frame_position_next = fp_inc[FP_W-1:0];
                end
            end
        end
        else if (!packet_finished_reg && in_word_reg == sfce_pkg::SYNC_WORD && sync_fits)
        begin
            in_frame_next       = 1'b1;
            frame_selected_next = 1'b0;
            frame_position_next = FP_W'(1);
        end

        if (packet_wrap)
        begin
            packet_position_next = '0;
            frame_position_next  = '0;
            in_frame_next        = 1'b0;
            frame_selected_next  = 1'b0;
            scans_done_next      = '0;
            slot_in_scan_next    = '0;
            scan_open_next       = 1'b0;
            packet_finished_next = 1'b0;
        end
        else
        begin
            packet_position_next = packet_position_reg + sfce_pkg::PKT_W'(1);
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= sample_word;
        end
    end

    // packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_position_reg <= '0;
            frame_position_reg  <= '0;
            in_frame_reg        <= 1'b0;
            frame_selected_reg  <= 1'b0;
            scans_done_reg      <= '0;
            slot_in_scan_reg    <= '0;
            scan_open_reg       <= 1'b0;
            packet_finished_reg <= 1'b0;
        end
        else if (advance)
        begin
            packet_position_reg <= packet_position_next;
            frame_position_reg  <= frame_position_next;
            in_frame_reg        <= in_frame_next;
            frame_selected_reg  <= frame_selected_next;
            scans_done_reg      <= scans_done_next;
            slot_in_scan_reg    <= slot_in_scan_next;
            scan_open_reg       <= scan_open_next;
            packet_finished_reg <= packet_finished_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            payload_word_reg <= in_word_reg;
            scan_index_reg   <= emit_index;
            dest_offset_reg  <= emit_offset;
            frame_end_reg    <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_word = payload_word_reg;
    assign scan_index   = scan_index_reg;
    assign dest_offset  = dest_offset_reg;
    assign frame_end    = frame_end_reg;

endmodule

`default_nettype wire
